@@ hdl/tcwp_pkg.sv @@
package tcwp_pkg;

    localparam int MODE_W  = 2;
    localparam int CHAR_W  = 8;
    localparam int DELTA_W = 8;
    localparam int INDEX_W = 11;
    localparam int CELL_W  = 16;
    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;

    localparam logic [MODE_W-1:0] MODE_CHAR    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POINTER = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ    = 2'd2;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;

    typedef enum logic [8:0] {
        ST_INIT    = 9'b000000001,
        ST_IDLE    = 9'b000000010,
        ST_CHR     = 9'b000000100,
        ST_PTR_OLD = 9'b000001000,
        ST_PTR_RD  = 9'b000010000,
        ST_PTR_NEW = 9'b000100000,
        ST_CELL    = 9'b001000000,
        ST_SCRUB   = 9'b010000000,
        ST_FINISH  = 9'b100000000
    } state_t;

    // Exchange foreground and background nibbles of the attribute byte
    function automatic logic [CELL_W-1:0] swap_attr(input logic [CELL_W-1:0] v);
        swap_attr = {v[11:8], v[15:12], v[7:0]};
    endfunction

endpackage

@@ hdl/tcwp_ram.sv @@
module tcwp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hdl/text_console_with_pointer_core.sv @@
// Text console: a COLUMNS x ROWS store of 16-bit cells (attribute high byte,
// character low byte) with a write cursor and a pointer.
// Input stream: s_tuser carries the mode (0 write character, 1 move pointer,
// 2 read cell); s_tdata carries the operands. Each input transfer yields one
// output transfer with the read cell and the cursor and pointer positions.
// One item is worked at a time through a read-modify-write on the cell RAM:
// mode 0 reads the cursor cell and rewrites its character (a newline writes
// nothing), mode 1 updates two cells (the old and the new pointer cell), mode 2
// reads one cell and mode 3 touches no cell. The next item is taken the cycle
// after the result is loaded, so no new item is accepted before that point.
// A character that scrolls past the last row rewrites every character to a
// space, one cell per cycle.
// After reset the RAM is zeroed one cell per cycle, with s_tready low. The
// result sits in an output register: while m_tready is low the next item is
// still accepted and worked, and its result waits until the register frees.
module text_console_with_pointer_core #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // mode
    input  logic [tcwp_pkg::MODE_W-1:0]        s_tuser,
    // char_code, delta_col, delta_row, cell_index, zero pad
    input  logic [tcwp_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // read_cell, text_col, text_row, pointer_col, pointer_row
    output logic [tcwp_pkg::OUT_DATA_W-1:0]    m_tdata
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CNT_W = $clog2(CELLS + 1);
    localparam int IDX_W = (AW > tcwp_pkg::INDEX_W) ? AW : tcwp_pkg::INDEX_W;

    tcwp_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]                   cnt_reg, cnt_next;
    logic [tcwp_pkg::COL_W-1:0]         write_col_reg, write_col_next;
    logic [tcwp_pkg::ROW_W-1:0]         write_row_reg, write_row_next;
    logic [tcwp_pkg::COL_W-1:0]         mouse_col_reg, mouse_col_next;
    logic [tcwp_pkg::ROW_W-1:0]         mouse_row_reg, mouse_row_next;
    logic                               m_tvalid_reg, m_tvalid_next;
    logic [tcwp_pkg::OUT_DATA_W-1:0]    m_tdata_reg, m_tdata_next;

    logic [tcwp_pkg::CHAR_W-1:0]        char_reg, char_next;
    logic signed [tcwp_pkg::DELTA_W-1:0] dcol_reg, dcol_next;
    logic signed [tcwp_pkg::DELTA_W-1:0] drow_reg, drow_next;
    logic                               idx_ok_reg, idx_ok_next;
    logic [tcwp_pkg::CELL_W-1:0]        read_reg, read_next;

    logic                               ram_we, ram_re;
    logic [AW-1:0]                      ram_wa, ram_ra;
    logic [tcwp_pkg::CELL_W-1:0]        ram_wd, ram_rd;

    logic [AW-1:0]                      cur_addr, ptr_addr, idx_addr;
    logic [IDX_W-1:0]                   idx_ext;
    logic [CNT_W-1:0]                   scrub_prev;
    logic                               in_xfer;
    logic                               is_newline;
    logic [tcwp_pkg::COL_W:0]           col_inc;
    logic [tcwp_pkg::ROW_W:0]           row_inc, row_new;
    logic                               line_wrap;
    logic signed [9:0]                  col_sum, row_sum;

    assign s_tready   = (state_reg == tcwp_pkg::ST_IDLE);
    assign in_xfer    = s_tvalid && s_tready;
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;

    assign cur_addr   = AW'(AW'(write_row_reg) * AW'(COLUMNS) + AW'(write_col_reg));
    assign ptr_addr   = AW'(AW'(mouse_row_reg) * AW'(COLUMNS) + AW'(mouse_col_reg));
    assign idx_ext    = IDX_W'(s_tdata[34:24]);
    assign idx_addr   = idx_ext[AW-1:0];
    assign scrub_prev = cnt_reg - CNT_W'(1);

    assign is_newline = (char_reg == tcwp_pkg::NEWLINE_CODE);
    assign col_inc    = {1'b0, write_col_reg} + 8'd1;
    assign line_wrap  = is_newline || (col_inc >= 8'(COLUMNS));
    assign row_inc    = {1'b0, write_row_reg} + 6'd1;
    assign row_new    = line_wrap ? row_inc : {1'b0, write_row_reg};

    assign col_sum    = $signed({3'b000, mouse_col_reg}) + 10'(dcol_reg);
    assign row_sum    = $signed({5'b00000, mouse_row_reg}) + 10'(drow_reg);

    tcwp_ram #(
        .WIDTH (tcwp_pkg::CELL_W),
        .DEPTH (CELLS)
    ) u_cells (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_wa),
        .wr_data (ram_wd),
        .rd_en   (ram_re),
        .rd_addr (ram_ra),
        .rd_data (ram_rd)
    );

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        write_col_next = write_col_reg;
        write_row_next = write_row_reg;
        mouse_col_next = mouse_col_reg;
        mouse_row_next = mouse_row_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        char_next      = char_reg;
        dcol_next      = dcol_reg;
        drow_next      = drow_reg;
        idx_ok_next    = idx_ok_reg;
        read_next      = read_reg;
        ram_we         = 1'b0;
        ram_wa         = cur_addr;
        ram_wd         = {ram_rd[15:8], char_reg};
        ram_re         = 1'b0;
        ram_ra         = cur_addr;

        case (state_reg)
            tcwp_pkg::ST_INIT:
            begin
                // zero the store after reset
                ram_we = 1'b1;
                ram_wa = cnt_reg[AW-1:0];
                ram_wd = '0;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(CELLS - 1))
                begin
                    cnt_next   = '0;
                    state_next = tcwp_pkg::ST_IDLE;
                end
            end
            tcwp_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    char_next   = s_tdata[7:0];
                    dcol_next   = s_tdata[15:8];
                    drow_next   = s_tdata[23:16];
                    idx_ok_next = (idx_ext < IDX_W'(CELLS));
                    read_next   = '0;
                    ram_re      = 1'b1;
                    case (s_tuser)
                        tcwp_pkg::MODE_CHAR:
                        begin
                            ram_ra     = cur_addr;
                            state_next = tcwp_pkg::ST_CHR;
                        end
                        tcwp_pkg::MODE_POINTER:
                        begin
                            ram_ra     = ptr_addr;
                            state_next = tcwp_pkg::ST_PTR_OLD;
                        end
                        tcwp_pkg::MODE_READ:
                        begin
                            ram_ra     = idx_addr;
                            state_next = tcwp_pkg::ST_CELL;
                        end
                        default:
                        begin
                            ram_re     = 1'b0;
                            state_next = tcwp_pkg::ST_FINISH;
                        end
                    endcase
                end
            end
            tcwp_pkg::ST_CHR:
            begin
                // keep the attribute, replace the character
                ram_we = !is_newline;
                ram_wa = cur_addr;
                ram_wd = {ram_rd[15:8], char_reg};
                write_col_next = line_wrap ? '0 : col_inc[tcwp_pkg::COL_W-1:0];
                write_row_next = row_new[tcwp_pkg::ROW_W-1:0];
                state_next     = tcwp_pkg::ST_FINISH;
                if (row_new >= 6'(ROWS))
                begin
                    write_col_next = '0;
                    write_row_next = '0;
                    cnt_next       = '0;
                    state_next     = tcwp_pkg::ST_SCRUB;
                end
            end
            tcwp_pkg::ST_PTR_OLD:
            begin
                ram_we = 1'b1;
                ram_wa = ptr_addr;
                ram_wd = tcwp_pkg::swap_attr(ram_rd);
                if (col_sum < 0)
                    mouse_col_next = '0;
                else if (col_sum >= $signed(10'(COLUMNS)))
                    mouse_col_next = tcwp_pkg::COL_W'(COLUMNS - 1);
                else
                    mouse_col_next = col_sum[tcwp_pkg::COL_W-1:0];
                if (row_sum < 0)
                    mouse_row_next = '0;
                else if (row_sum >= $signed(10'(ROWS)))
                    mouse_row_next = tcwp_pkg::ROW_W'(ROWS - 1);
                else
                    mouse_row_next = row_sum[tcwp_pkg::ROW_W-1:0];
                state_next = tcwp_pkg::ST_PTR_RD;
            end
            tcwp_pkg::ST_PTR_RD:
            begin
                // old cell was written last cycle, so a same-cell read sees it
                ram_re     = 1'b1;
                ram_ra     = ptr_addr;
                state_next = tcwp_pkg::ST_PTR_NEW;
            end
            tcwp_pkg::ST_PTR_NEW:
            begin
                ram_we     = 1'b1;
                ram_wa     = ptr_addr;
                ram_wd     = tcwp_pkg::swap_attr(ram_rd);
                state_next = tcwp_pkg::ST_FINISH;
            end
            tcwp_pkg::ST_CELL:
            begin
                read_next  = idx_ok_reg ? ram_rd : '0;
                state_next = tcwp_pkg::ST_FINISH;
            end
            tcwp_pkg::ST_SCRUB:
            begin
                // read cell n while writing back cell n-1 with a space
                ram_re = (cnt_reg < CNT_W'(CELLS));
                ram_ra = cnt_reg[AW-1:0];
                ram_we = (cnt_reg != '0);
                ram_wa = scrub_prev[AW-1:0];
                ram_wd = {ram_rd[15:8], tcwp_pkg::SPACE_CODE};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(CELLS))
                begin
                    cnt_next   = '0;
                    state_next = tcwp_pkg::ST_FINISH;
                end
            end
            tcwp_pkg::ST_FINISH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {mouse_row_reg, mouse_col_reg,
                                     write_row_reg, write_col_reg, read_reg};
                    state_next    = tcwp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tcwp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tcwp_pkg::ST_INIT;
            cnt_reg       <= '0;
            write_col_reg <= '0;
            write_row_reg <= '0;
            mouse_col_reg <= tcwp_pkg::COL_W'(COLUMNS / 2);
            mouse_row_reg <= tcwp_pkg::ROW_W'(ROWS / 2);
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            write_col_reg <= write_col_next;
            write_row_reg <= write_row_next;
            mouse_col_reg <= mouse_col_next;
            mouse_row_reg <= mouse_row_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        char_reg    <= char_next;
        dcol_reg    <= dcol_next;
        drow_reg    <= drow_next;
        idx_ok_reg  <= idx_ok_next;
        read_reg    <= read_next;
    end

`ifndef SYNTHESIS
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (write_col_reg < tcwp_pkg::COL_W'(COLUMNS)) &&
        (write_row_reg < tcwp_pkg::ROW_W'(ROWS)))
        else $error("write cursor outside the screen");

    a_pointer_range: assert property (@(posedge clk) disable iff (!rst_n)
        (mouse_col_reg < tcwp_pkg::COL_W'(COLUMNS)) &&
        (mouse_row_reg < tcwp_pkg::ROW_W'(ROWS)))
        else $error("pointer outside the screen");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg != tcwp_pkg::ST_IDLE))
        else $error("accepted item did not start");

    a_scrub_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tcwp_pkg::ST_SCRUB) && (cnt_reg == CNT_W'(CELLS))
        |=> (state_reg == tcwp_pkg::ST_FINISH))
        else $error("screen clear did not finish");

    a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tcwp_pkg::ST_FINISH) && (!m_tvalid_reg || m_tready) |=> m_tvalid_reg)
        else $error("result not presented");
`endif

endmodule
